// ===== hw/rtl/rce_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Relay candidate enumerator package
// Shared widths, action codes, register indexes and state types.
// ----------------------------------------------------------------------------
package rce_pkg;

    // Width of one relay address and of the scan indexes.
    localparam int RELAY_W = 8;
    localparam int IDX_W   = 7;

    // Configuration port geometry.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEST_ADDR  = 1'b1;

    // Action codes carried by an input item.
    typedef enum logic [1:0] {
        ACT_WRITE   = 2'd0,
        ACT_NEXT    = 2'd1,
        ACT_RESTART = 2'd2
    } action_t;

    // Which part of the enumeration is running.
    typedef enum logic [1:0] {
        SER_NONE   = 2'd0,
        SER_SINGLE = 2'd1,
        SER_PAIR   = 2'd2
    } series_t;

    // Control sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SEARCH,
        ST_RESULT
    } state_t;

endpackage : rce_pkg
`default_nettype wire

// ===== hw/rtl/relay_candidate_enumerator_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Relay candidate enumerator core
// Keeps a relay address table and hands out single and paired relay routes.
// ----------------------------------------------------------------------------
// A write or restart item completes in the idle state. A next item first scans
// the table for an entry that differs from the destination, one entry per
// cycle and stopping at the first one; if there is none, a not-found result
// is produced. Otherwise it then steps through the candidate order at one
// step per cycle, each step reading the first and second slot through the
// two table read ports, until a route is found. The result moves from the
// result registers to the output register, and a stalled receiver holds it
// back. The table is not cleared at reset; slots must be written before a
// next item reads them.
module relay_candidate_enumerator_core #(
    parameter int TABLE_DEPTH = 64
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // Configuration write port.
    input  wire logic                           cfg_we,
    input  wire logic [rce_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [rce_pkg::CFG_DATA_W-1:0] cfg_data,
    // Input items.
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [1:0]                     action,
    input  wire logic [5:0]                     entry_index,
    input  wire logic [7:0]                     entry_value,
    // Result items.
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic                                found,
    output logic      [1:0]                     hop_count,
    output logic      [7:0]                     first_relay,
    output logic      [7:0]                     second_relay
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int IW = (AW > rce_pkg::IDX_W) ? AW : rce_pkg::IDX_W;

    // Control and configuration registers.
    rce_pkg::state_t               state_reg, state_next;
    rce_pkg::series_t              series_reg, series_next;
    logic [rce_pkg::IDX_W-1:0]     fi_reg, fi_next;
    logic [rce_pkg::IDX_W-1:0]     si_reg, si_next;
    logic [rce_pkg::IDX_W-1:0]     scan_cnt_reg, scan_cnt_next;
    logic                          pend_reg, pend_next;
    logic [rce_pkg::IDX_W-1:0]     node_count_reg;
    logic [rce_pkg::RELAY_W-1:0]   dest_addr_reg;
    logic                          out_valid_reg, out_valid_next;

    // Result payload registers.
    logic                          res_found_reg, res_found_next;
    logic [1:0]                    res_hop_reg, res_hop_next;
    logic [rce_pkg::RELAY_W-1:0]   res_first_reg, res_first_next;
    logic [rce_pkg::RELAY_W-1:0]   res_second_reg, res_second_next;
    logic                          out_found_reg;
    logic [1:0]                    out_hop_reg;
    logic [rce_pkg::RELAY_W-1:0]   out_first_reg;
    logic [rce_pkg::RELAY_W-1:0]   out_second_reg;

    // Table access.
    logic                          ram_we;
    logic [IW-1:0]                 waddr_wide;
    logic [rce_pkg::IDX_W-1:0]     rd_idx_a, rd_idx_b;
    logic [IW-1:0]                 raddr_a_wide, raddr_b_wide;
    logic [rce_pkg::RELAY_W-1:0]   rd_a, rd_b;

    // Decision terms.
    logic                          in_acc;
    logic                          out_load;
    logic [rce_pkg::IDX_W-1:0]     eff_cnt;
    logic                          scan_any, scan_none;
    logic                          a_use, b_use, a_ok, b_ok, hit;
    logic [rce_pkg::IDX_W-1:0]     fi_inc, si_inc;

    // Effective entry count is node_count limited to the table depth.
    always_comb
    begin
        if (9'(node_count_reg) > 9'(TABLE_DEPTH))
        begin
            eff_cnt = rce_pkg::IDX_W'(TABLE_DEPTH);
        end
        else
        begin
            eff_cnt = node_count_reg;
        end
    end

    assign in_ready = (state_reg == rce_pkg::ST_IDLE);
    assign in_acc   = in_valid && in_ready;
    assign out_load = (state_reg == rce_pkg::ST_RESULT) && (!out_valid_reg || out_ready);

    // Table scan: data of the previous index arrives this cycle.
    assign scan_any  = pend_reg && (rd_a != dest_addr_reg);
    assign scan_none = !pend_reg && (scan_cnt_reg >= eff_cnt);

    // Candidate check on the slots read last cycle.
    assign a_use  = (rd_a != dest_addr_reg);
    assign b_use  = (rd_b != dest_addr_reg);
    assign a_ok   = (fi_reg < eff_cnt);
    assign b_ok   = (si_reg < eff_cnt);
    assign fi_inc = fi_reg + rce_pkg::IDX_W'(1);
    assign si_inc = si_reg + rce_pkg::IDX_W'(1);

    always_comb
    begin
        if (series_reg == rce_pkg::SER_PAIR)
        begin
            hit = a_ok && b_ok && (fi_reg != si_reg) && a_use && b_use;
        end
        else
        begin
            hit = a_ok && a_use;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rce_pkg::ST_IDLE:
            begin
                if (in_acc && (rce_pkg::action_t'(action) == rce_pkg::ACT_NEXT))
                begin
                    state_next = rce_pkg::ST_SCAN;
                end
            end
            rce_pkg::ST_SCAN:
            begin
                if (scan_any)
                begin
                    state_next = rce_pkg::ST_SEARCH;
                end
                else if (scan_none)
                begin
                    state_next = rce_pkg::ST_RESULT;
                end
            end
            rce_pkg::ST_SEARCH:
            begin
                if (hit)
                begin
                    state_next = rce_pkg::ST_RESULT;
                end
            end
            rce_pkg::ST_RESULT:
            begin
                if (out_load)
                begin
                    state_next = rce_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rce_pkg::ST_IDLE;
            end
        endcase
    end

    // Enumeration state, result and table read addresses.
    always_comb
    begin
        series_next     = series_reg;
        fi_next         = fi_reg;
        si_next         = si_reg;
        scan_cnt_next   = scan_cnt_reg;
        pend_next       = pend_reg;
        res_found_next  = res_found_reg;
        res_hop_next    = res_hop_reg;
        res_first_next  = res_first_reg;
        res_second_next = res_second_reg;
        ram_we          = 1'b0;

        case (state_reg)
            rce_pkg::ST_IDLE:
            begin
                if (in_acc)
                begin
                    case (rce_pkg::action_t'(action))
                        rce_pkg::ACT_WRITE:
                        begin
                            ram_we = (8'(entry_index) < 8'(TABLE_DEPTH));
                        end
                        rce_pkg::ACT_NEXT:
                        begin
                            scan_cnt_next = '0;
                            pend_next     = 1'b0;
                        end
                        rce_pkg::ACT_RESTART:
                        begin
                            series_next = rce_pkg::SER_NONE;
                            fi_next     = '0;
                            si_next     = '0;
                        end
                        default:
                        begin
                            ram_we = 1'b0;
                        end
                    endcase
                end
            end
            rce_pkg::ST_SCAN:
            begin
                if (scan_any)
                begin
                    // A usable relay exists: start or resume the enumeration.
                    series_next = (series_reg == rce_pkg::SER_PAIR) ?
                                  rce_pkg::SER_PAIR : rce_pkg::SER_SINGLE;
                end
                else if (scan_none)
                begin
                    res_found_next  = 1'b0;
                    res_hop_next    = 2'd0;
                    res_first_next  = '0;
                    res_second_next = '0;
                end
                else
                begin
                    pend_next = (scan_cnt_reg < eff_cnt);
                    if (scan_cnt_reg < eff_cnt)
                    begin
                        scan_cnt_next = scan_cnt_reg + rce_pkg::IDX_W'(1);
                    end
                end
            end
            rce_pkg::ST_SEARCH:
            begin
                if (hit)
                begin
                    res_found_next = 1'b1;
                    res_first_next = rd_a;
                    fi_next        = fi_inc;
                    if (series_reg == rce_pkg::SER_PAIR)
                    begin
                        res_hop_next    = 2'd2;
                        res_second_next = rd_b;
                    end
                    else
                    begin
                        res_hop_next    = 2'd1;
                        res_second_next = '0;
                    end
                end
                else if (fi_inc >= eff_cnt)
                begin
                    // First slot ran past the end: step the second slot or switch between singles and pairs.
                    fi_next = '0;
                    if (series_reg == rce_pkg::SER_PAIR)
                    begin
                        si_next = si_inc;
                        if (si_inc >= eff_cnt)
                        begin
                            series_next = rce_pkg::SER_SINGLE;
                        end
                    end
                    else
                    begin
                        si_next     = '0;
                        series_next = rce_pkg::SER_PAIR;
                    end
                end
                else
                begin
                    fi_next = fi_inc;
                end
            end
            rce_pkg::ST_RESULT:
            begin
                ram_we = 1'b0;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase

        // Reads are issued for the indexes that the next cycle evaluates.
        if ((state_reg == rce_pkg::ST_SCAN) && !scan_any)
        begin
            rd_idx_a = scan_cnt_reg;
        end
        else
        begin
            rd_idx_a = fi_next;
        end
        rd_idx_b = si_next;
    end

    // Output register handoff.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Address formation from the index widths.
    assign waddr_wide   = IW'(entry_index);
    assign raddr_a_wide = IW'(rd_idx_a);
    assign raddr_b_wide = IW'(rd_idx_b);

    rce_table_ram #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_table (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (waddr_wide[AW-1:0]),
        .wdata   (entry_value),
        .raddr_a (raddr_a_wide[AW-1:0]),
        .raddr_b (raddr_b_wide[AW-1:0]),
        .rdata_a (rd_a),
        .rdata_b (rd_b)
    );

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= rce_pkg::ST_IDLE;
            series_reg     <= rce_pkg::SER_NONE;
            fi_reg         <= '0;
            si_reg         <= '0;
            scan_cnt_reg   <= '0;
            pend_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
            node_count_reg <= '0;
            dest_addr_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            series_reg    <= series_next;
            fi_reg        <= fi_next;
            si_reg        <= si_next;
            scan_cnt_reg  <= scan_cnt_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    rce_pkg::CFG_NODE_COUNT:
                    begin
                        node_count_reg <= cfg_data[rce_pkg::IDX_W-1:0];
                    end
                    rce_pkg::CFG_DEST_ADDR:
                    begin
                        dest_addr_reg <= cfg_data[rce_pkg::RELAY_W-1:0];
                    end
                    default:
                    begin
                        dest_addr_reg <= dest_addr_reg;
                    end
                endcase
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        res_found_reg  <= res_found_next;
        res_hop_reg    <= res_hop_next;
        res_first_reg  <= res_first_next;
        res_second_reg <= res_second_next;
        if (out_load)
        begin
            out_found_reg  <= res_found_reg;
            out_hop_reg    <= res_hop_reg;
            out_first_reg  <= res_first_reg;
            out_second_reg <= res_second_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign found        = out_found_reg;
    assign hop_count    = out_hop_reg;
    assign first_relay  = out_first_reg;
    assign second_relay = out_second_reg;

`ifndef SYNTHESIS
    // A not-found result carries all-zero fields.
    a_notfound_zero : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_found_reg |->
            out_hop_reg == 2'd0 && out_first_reg == '0 && out_second_reg == '0)
        else $error("not-found result has nonzero fields");

    // The candidate search only runs with a started series.
    a_search_series : assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == rce_pkg::ST_SEARCH |->
            series_reg == rce_pkg::SER_SINGLE || series_reg == rce_pkg::SER_PAIR)
        else $error("search running without a started series");

    // A new result only appears after the result state.
    a_result_source : assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == rce_pkg::ST_RESULT)
        else $error("result appeared outside the result state");

    // An accepted next item starts the table scan.
    a_next_starts_scan : assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && action == rce_pkg::ACT_NEXT |=>
            state_reg == rce_pkg::ST_SCAN)
        else $error("next item did not start the scan");
`endif

endmodule : relay_candidate_enumerator_core
`default_nettype wire

// ===== hw/rtl/rce_table_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Relay table memory
// One write port and two registered read ports.
// ----------------------------------------------------------------------------
module rce_table_ram #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  wire logic                        clk,
    input  wire logic                        we,
    input  wire logic [AW-1:0]               waddr,
    input  wire logic [rce_pkg::RELAY_W-1:0] wdata,
    input  wire logic [AW-1:0]               raddr_a,
    input  wire logic [AW-1:0]               raddr_b,
    output logic      [rce_pkg::RELAY_W-1:0] rdata_a,
    output logic      [rce_pkg::RELAY_W-1:0] rdata_b
);

    logic [rce_pkg::RELAY_W-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Two read ports with registered data.
    always_ff @(posedge clk)
    begin
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule : rce_table_ram
`default_nettype wire

// ===== test/relay_route_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Relay route checker
// Watches the configuration port and both item channels of the relay
// candidate enumerator, predicts the route that each next item yields and
// compares every returned route field by field, oldest prediction first.
// ----------------------------------------------------------------------------
module relay_route_checker #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [rce_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rce_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           in_valid,
    input  logic                           in_ready,
    input  logic [1:0]                     action,
    input  logic [5:0]                     entry_index,
    input  logic [7:0]                     entry_value,
    input  logic                           out_valid,
    input  logic                           out_ready,
    input  logic                           found,
    input  logic [1:0]                     hop_count,
    input  logic [7:0]                     first_relay,
    input  logic [7:0]                     second_relay,
    output int                             routes_pending,
    output int                             fail_count
);

    // Upper bound on scan steps for one route; a correct scan needs far fewer.
    localparam int STEP_GUARD = 200000;
    localparam int AW         = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    typedef struct packed {
        logic                        found;
        logic [1:0]                  hops;
        logic [rce_pkg::RELAY_W-1:0] first;
        logic [rce_pkg::RELAY_W-1:0] second;
    } route_t;

    // Shadow of the block state and its registers.
    logic [rce_pkg::RELAY_W-1:0] relay_copy [TABLE_DEPTH];
    rce_pkg::series_t            scan_series;
    logic [rce_pkg::IDX_W-1:0]   lead_idx;
    logic [rce_pkg::IDX_W-1:0]   trail_idx;
    logic [6:0]                  count_reg;
    logic [7:0]                  dest_reg;

    route_t routes_due [$];
    int     errors = 0;

    assign fail_count = errors;

    task automatic report(input string msg);
        if (errors < 40)
        begin
            $display("[%0t] route mismatch: %s", $time, msg);
        end
        errors++;
    endtask

    // Works out the next candidate route and advances the scan position.
    function automatic route_t next_route();
        route_t r;
        int     n;
        int     steps;
        logic   any;
        logic   hit;
        r = '0;
        n = (count_reg > TABLE_DEPTH) ? TABLE_DEPTH : int'(count_reg);
        any = 1'b0;
        for (int i = 0; i < n; i++)
        begin
            if (relay_copy[i[AW-1:0]] != dest_reg)
            begin
                any = 1'b1;
            end
        end
        // With no relay apart from the destination, nothing moves.
        if (!any)
        begin
            return r;
        end
        if (scan_series != rce_pkg::SER_PAIR)
        begin
            scan_series = rce_pkg::SER_SINGLE;
        end
        steps = 0;
        forever
        begin
            if (scan_series == rce_pkg::SER_SINGLE)
            begin
                hit = (lead_idx < n) && (relay_copy[lead_idx[AW-1:0]] != dest_reg);
            end
            else
            begin
                hit = (lead_idx < n) && (trail_idx < n) && (lead_idx != trail_idx) &&
                      (relay_copy[lead_idx[AW-1:0]] != dest_reg) &&
                      (relay_copy[trail_idx[AW-1:0]] != dest_reg);
            end
            if (hit)
            begin
                break;
            end
            // The first slot runs fastest; its wrap steps the second slot
            // or moves from singles to pairs and back.
            lead_idx = lead_idx + 1'b1;
            if (lead_idx >= n)
            begin
                lead_idx = '0;
                if (scan_series == rce_pkg::SER_SINGLE)
                begin
                    trail_idx   = '0;
                    scan_series = rce_pkg::SER_PAIR;
                end
                else
                begin
                    trail_idx = trail_idx + 1'b1;
                    if (trail_idx >= n)
                    begin
                        scan_series = rce_pkg::SER_SINGLE;
                    end
                end
            end
            steps++;
            if (steps >= STEP_GUARD)
            begin
                return r;
            end
        end
        r.found = 1'b1;
        r.first = relay_copy[lead_idx[AW-1:0]];
        if (scan_series == rce_pkg::SER_SINGLE)
        begin
            r.hops = 2'd1;
        end
        else
        begin
            r.hops   = 2'd2;
            r.second = relay_copy[trail_idx[AW-1:0]];
        end
        lead_idx = lead_idx + 1'b1;
        return r;
    endfunction

    // Track configuration and items; check each route as it is taken.
    always @(posedge clk or negedge rst_n)
    begin : watch
        route_t got;
        route_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < TABLE_DEPTH; i++)
            begin
                relay_copy[i[AW-1:0]] = '0;
            end
            scan_series = rce_pkg::SER_NONE;
            lead_idx    = '0;
            trail_idx   = '0;
            count_reg   = '0;
            dest_reg    = '0;
            routes_due.delete();
            routes_pending <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    rce_pkg::CFG_NODE_COUNT: count_reg = cfg_data[6:0];
                    rce_pkg::CFG_DEST_ADDR:  dest_reg  = cfg_data;
                    default: ;
                endcase
            end

            // Returned route against the oldest prediction.
            if (out_valid && out_ready)
            begin
                got = {found, hop_count, first_relay, second_relay};
                if (routes_due.size() == 0)
                begin
                    report($sformatf("route with none due: found=%0d hops=%0d relays %0h/%0h",
                                     found, hop_count, first_relay, second_relay));
                end
                else
                begin
                    want = routes_due.pop_front();
                    if (got.found !== want.found)
                        report($sformatf("found %0d, want %0d", got.found, want.found));
                    if (got.hops !== want.hops)
                        report($sformatf("hop_count %0d, want %0d", got.hops, want.hops));
                    if (got.first !== want.first)
                        report($sformatf("first_relay %0h, want %0h", got.first, want.first));
                    if (got.second !== want.second)
                        report($sformatf("second_relay %0h, want %0h", got.second, want.second));
                end
            end

            // Accepted item updates the shadow state.
            if (in_valid && in_ready)
            begin
                case (action)
                    rce_pkg::ACT_WRITE:
                    begin
                        if (entry_index < TABLE_DEPTH)
                        begin
                            relay_copy[entry_index] = entry_value;
                        end
                    end
                    rce_pkg::ACT_NEXT:
                    begin
                        routes_due.push_back(next_route());
                    end
                    rce_pkg::ACT_RESTART:
                    begin
                        scan_series = rce_pkg::SER_NONE;
                        lead_idx    = '0;
                        trail_idx   = '0;
                    end
                    default: ;
                endcase
            end
            routes_pending <= routes_due.size();
        end
    end

endmodule

// ===== test/relay_candidate_enumerator_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Relay candidate enumerator testbench
// Fills the relay table, walks directed route sequences through singles,
// pairs, wrap, restart, shrinking counts and the no-relay case, then runs
// random phases of configuration and items with random idling on both sides.
// ----------------------------------------------------------------------------
module relay_candidate_enumerator_core_tb;

    localparam logic [1:0] ACT_UNUSED   = 2'd3;
    localparam int         RANDOM_ITEMS = 620;
    localparam int         STALL_LIMIT  = 20000;
    localparam int         SETTLE       = 8;

    logic                           clk          = 1'b0;
    logic                           rst_n        = 1'b0;
    logic                           cfg_we       = 1'b0;
    logic [rce_pkg::CFG_IDX_W-1:0]  cfg_index    = '0;
    logic [rce_pkg::CFG_DATA_W-1:0] cfg_data     = '0;
    logic                           in_valid     = 1'b0;
    logic                           in_ready;
    logic [1:0]                     action       = '0;
    logic [5:0]                     entry_index  = '0;
    logic [7:0]                     entry_value  = '0;
    logic                           out_valid;
    logic                           out_ready    = 1'b0;
    logic                           found;
    logic [1:0]                     hop_count;
    logic [7:0]                     first_relay;
    logic [7:0]                     second_relay;

    int   pending_routes;
    int   route_failures;
    int   quiet_cycles = 0;
    logic calm         = 1'b0;

    // Copy of what was written to the table, used to pick destinations.
    logic [7:0] table_img [64];

    relay_candidate_enumerator_core DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .action       (action),
        .entry_index  (entry_index),
        .entry_value  (entry_value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .found        (found),
        .hop_count    (hop_count),
        .first_relay  (first_relay),
        .second_relay (second_relay)
    );

    relay_route_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .action         (action),
        .entry_index    (entry_index),
        .entry_value    (entry_value),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .found          (found),
        .hop_count      (hop_count),
        .first_relay    (first_relay),
        .second_relay   (second_relay),
        .routes_pending (pending_routes),
        .fail_count     (route_failures)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // The receiver stalls at random except in the calm stretch.
    always @(posedge clk)
    begin
        out_ready <= calm || ($urandom_range(99) >= 34);
    end

    // Ends the run when nothing is taken on any port for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("relay_candidate_enumerator_core_tb NOT OK");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offers one item, with a random gap before it, and waits until taken.
    task automatic send_item(input logic [1:0] act, input logic [5:0] idx,
                             input logic [7:0] val);
        if (!calm)
        begin
            while ($urandom_range(99) < 34)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid    <= 1'b1;
        action      <= act;
        entry_index <= idx;
        entry_value <= val;
        do
            @(posedge clk);
        while (!in_ready);
        if (act == rce_pkg::ACT_WRITE)
        begin
            table_img[idx] = val;
        end
    endtask

    // Stops offering items and waits until every route has come back.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_routes != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE) @(posedge clk);
    endtask

    // Writes both registers once the block has gone quiet.
    task automatic configure(input int count, input int dest);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= rce_pkg::CFG_NODE_COUNT;
        cfg_data  <= count[rce_pkg::CFG_DATA_W-1:0];
        @(posedge clk);
        cfg_index <= rce_pkg::CFG_DEST_ADDR;
        cfg_data  <= dest[rce_pkg::CFG_DATA_W-1:0];
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    initial
    begin : stimulus
        int         random_items;
        int         count;
        int         eff;
        int         dest;
        int         len;
        int         pick;
        logic [5:0] idx;
        logic [7:0] val;

        for (int i = 0; i < 64; i++)
        begin
            table_img[i[5:0]] = '0;
        end
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Straight out of reset the count is zero, so no route exists.
        send_item(rce_pkg::ACT_NEXT, 6'h3F, 8'hFF);
        send_item(ACT_UNUSED, 6'h00, 8'h00);
        send_item(rce_pkg::ACT_RESTART, 6'h2A, 8'h55);

        // Fill the whole table so no scan ever reads an unwritten slot.
        for (int i = 0; i < 64; i++)
        begin
            case (i)
                0:       val = 8'h00;
                1:       val = 8'hFF;
                2:       val = 8'h55;
                3, 4:    val = 8'hAA;
                63:      val = 8'h81;
                default: val = 8'($urandom_range(255));
            endcase
            send_item(rce_pkg::ACT_WRITE, i[5:0], val);
        end

        // Five slots, one of them the destination: singles, then pairs
        // deep enough that the second slot sits at index three.
        configure(5, 255);
        repeat (11) send_item(rce_pkg::ACT_NEXT, 6'($urandom_range(63)),
                              8'($urandom_range(255)));

        // Shrinking the count leaves a stale second slot; the scan must
        // fall back to singles.
        configure(2, 255);
        repeat (2) send_item(rce_pkg::ACT_NEXT, 6'h00, 8'h00);
        send_item(rce_pkg::ACT_RESTART, 6'h15, 8'hAA);

        // Every counted entry equals the destination.
        send_item(rce_pkg::ACT_WRITE, 6'd0, 8'hAA);
        send_item(rce_pkg::ACT_WRITE, 6'd1, 8'hAA);
        configure(2, 170);
        send_item(rce_pkg::ACT_NEXT, 6'h3F, 8'hFF);

        // Full table, and a count beyond the table depth.
        configure(64, 0);
        repeat (2) send_item(rce_pkg::ACT_NEXT, 6'h00, 8'h00);
        configure(127, 129);
        repeat (2) send_item(rce_pkg::ACT_NEXT, 6'h3F, 8'hFF);

        // Random phases: mostly small counts, a few full-size ones.
        random_items = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            pick = $urandom_range(99);
            if (pick < 80)
                count = $urandom_range(8, 0);
            else if (pick < 90)
                count = $urandom_range(63, 9);
            else if (pick < 96)
                count = 64;
            else
                count = $urandom_range(127, 65);
            eff = (count > 64) ? 64 : count;
            if (eff > 0 && $urandom_range(1) == 1)
                dest = int'(table_img[6'($urandom_range(eff - 1, 0))]);
            else
                dest = $urandom_range(255);
            configure(count, dest);

            // Now and then make every counted entry the destination.
            if (eff > 0 && eff <= 8 && $urandom_range(9) == 0)
            begin
                for (int i = 0; i < eff; i++)
                begin
                    send_item(rce_pkg::ACT_WRITE, i[5:0], dest[7:0]);
                    random_items++;
                end
            end

            len = (eff > 8) ? $urandom_range(12, 4) : $urandom_range(40, 10);
            repeat (len)
            begin
                calm = (random_items >= 300) && (random_items < 420);
                pick = $urandom_range(99);
                if (pick < 65)
                begin
                    send_item(rce_pkg::ACT_NEXT, 6'($urandom_range(63)),
                              8'($urandom_range(255)));
                    random_items++;
                end
                else if (pick < 83)
                begin
                    if (eff > 0 && $urandom_range(2) != 0)
                        idx = 6'($urandom_range(eff - 1, 0));
                    else
                        idx = 6'($urandom_range(63));
                    val = ($urandom_range(2) == 0) ? dest[7:0] : 8'($urandom_range(255));
                    send_item(rce_pkg::ACT_WRITE, idx, val);
                    random_items++;
                end
                else if (pick < 93)
                begin
                    send_item(rce_pkg::ACT_RESTART, 6'($urandom_range(63)),
                              8'($urandom_range(255)));
                    random_items++;
                end
                else
                begin
                    send_item(ACT_UNUSED, 6'($urandom_range(63)), 8'($urandom_range(255)));
                end
            end
        end
        calm = 1'b0;

        // Wait for the last routes, then watch for anything extra.
        drain();
        repeat (50) @(posedge clk);
        if (route_failures == 0)
        begin
            $display("relay_candidate_enumerator_core_tb OK");
        end
        else
        begin
            $display("relay_candidate_enumerator_core_tb NOT OK");
        end
        $finish;
    end

endmodule
